[hdl/tmcw_pkg.sv]
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants of the text-mode console writer: screen
// geometry, cell constants, command codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_WHITE = 16'h0F20;
  localparam logic [CELL_W-1:0] BLANK_PLAIN = 16'h0020;
  localparam logic [7:0]        CH_NEWLINE   = 8'd10;
  localparam logic [7:0]        CH_BACKSPACE = 8'd8;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // carry out the immediate part of an accepted item
    logic fill_wr;     // write the fill word at the sweep address
    logic blank_wr;    // write a white blank at the sweep address
    logic copy_rd;     // read the cell one row below the sweep address
    logic sweep_inc;
    logic sweep_clr;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic need_scroll;
    logic sweep_last_copy;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

[hdl/tmcw_screen_ram.sv]
// ----------------------------------------------------------------------------
// tmcw_screen_ram
// Screen memory of attribute and character words: one write port and one
// registered read port. The read data holds until the next read.
// ----------------------------------------------------------------------------
module tmcw_screen_ram
  import tmcw_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/tmcw_datapath.sv]
// ----------------------------------------------------------------------------
// tmcw_datapath
// Cursor registers, sweep address counter, memory port steering and the
// result register of the console writer.
// ----------------------------------------------------------------------------
module tmcw_datapath
  import tmcw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          ctl,
  output dp_status_t       st,
  input  logic [1:0]       cmd,
  input  logic [7:0]       char_code,
  input  logic [7:0]       attribute,
  input  logic             interpret_backspace,
  input  logic [ROW_W-1:0] read_row,
  input  logic [COL_W-1:0] read_col,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [COL_W-1:0] cursor_col_out,
  output logic [ROW_W-1:0] cursor_row_out,
  output logic [CELL_W-1:0] cell_value
);

  localparam logic [COL_W-1:0]  LAST_COL       = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW       = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_COPY_CELL = ADDR_W'(CELLS - COLS - 1);

  logic [COL_W-1:0]  cursor_col, cursor_col_next;
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;
  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] copy_addr;
  logic              copy_pend;
  logic [CELL_W-1:0] fill_val;
  logic              rd_item;

  logic [ADDR_W-1:0] cur_addr, rd_addr;
  logic              is_put, is_nl, is_bs, rd_in_range, at_row_end;
  logic              put_we;
  logic [ADDR_W-1:0] put_addr;
  logic [CELL_W-1:0] put_data;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  assign cur_addr = ADDR_W'(ADDR_W'(cursor_row) * ADDR_W'(COLS)) + ADDR_W'(cursor_col);
  assign rd_addr  = ADDR_W'(ADDR_W'(read_row) * ADDR_W'(COLS)) + ADDR_W'(read_col);

  assign is_put      = (cmd_t'(cmd) == CMD_PUT);
  assign is_nl       = (char_code == CH_NEWLINE);
  assign is_bs       = (char_code == CH_BACKSPACE) && interpret_backspace;
  assign at_row_end  = (cursor_col == LAST_COL);
  assign rd_in_range = (read_row < ROW_W'(ROWS)) && (read_col < COL_W'(COLS));

  assign st.is_clear        = (cmd_t'(cmd) == CMD_CLEAR);
  assign st.need_scroll     = is_put && !is_bs && (is_nl || at_row_end)
                              && (cursor_row == LAST_ROW);
  assign st.sweep_last_copy = (sweep_addr == LAST_COPY_CELL);
  assign st.sweep_last      = (sweep_addr == LAST_CELL);
  assign st.out_free        = !out_valid || out_ready;

  // Immediate effect of a put: cursor movement and at most one cell write.
  // Moving past the last row leaves the cursor on the last row; the scroll
  // sweep that follows does the rest.
  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    put_we          = 1'b0;
    put_addr        = cur_addr;
    put_data        = {attribute, char_code};
    if (is_nl) begin
      cursor_col_next = '0;
      if (cursor_row != LAST_ROW) begin
        cursor_row_next = cursor_row + ROW_W'(1);
      end
    end else if (is_bs) begin
      if (cursor_col != '0) begin
        cursor_col_next = cursor_col - COL_W'(1);
        put_we          = 1'b1;
        put_addr        = cur_addr - ADDR_W'(1);
        put_data        = BLANK_WHITE;
      end
    end else begin
      put_we = 1'b1;
      if (at_row_end) begin
        cursor_col_next = '0;
        if (cursor_row != LAST_ROW) begin
          cursor_row_next = cursor_row + ROW_W'(1);
        end
      end else begin
        cursor_col_next = cursor_col + COL_W'(1);
      end
    end
  end

  // A copy read issued in one cycle is written back one row up in the next.
  always_comb begin
    we    = 1'b0;
    waddr = sweep_addr;
    wdata = fill_val;
    if (copy_pend) begin
      we    = 1'b1;
      waddr = copy_addr;
      wdata = rdata;
    end else if (ctl.fill_wr) begin
      we = 1'b1;
    end else if (ctl.blank_wr) begin
      we    = 1'b1;
      wdata = BLANK_WHITE;
    end else if (ctl.accept && is_put && put_we) begin
      we    = 1'b1;
      waddr = put_addr;
      wdata = put_data;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = sweep_addr + ADDR_W'(COLS);
    if (ctl.copy_rd) begin
      re = 1'b1;
    end else if (ctl.accept && (cmd_t'(cmd) == CMD_READ) && rd_in_range) begin
      re    = 1'b1;
      raddr = rd_addr;
    end
  end

  tmcw_screen_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      sweep_addr <= '0;
      copy_pend  <= 1'b0;
      fill_val   <= BLANK_PLAIN;
      out_valid  <= 1'b0;
    end else begin
      copy_pend <= ctl.copy_rd;
      if (ctl.accept) begin
        if (is_put) begin
          cursor_col <= cursor_col_next;
          cursor_row <= cursor_row_next;
        end else if (st.is_clear) begin
          cursor_col <= '0;
          cursor_row <= '0;
          fill_val   <= {attribute[3:0], 4'h0, 8'h00} | BLANK_PLAIN;
        end
      end
      if (ctl.sweep_clr) begin
        sweep_addr <= '0;
      end else if (ctl.sweep_inc) begin
        sweep_addr <= sweep_addr + ADDR_W'(1);
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.copy_rd) begin
      copy_addr <= sweep_addr;
    end
    if (ctl.accept) begin
      rd_item <= (cmd_t'(cmd) == CMD_READ) && rd_in_range;
    end
    if (ctl.out_load) begin
      cursor_col_out <= cursor_col;
      cursor_row_out <= cursor_row;
      cell_value     <= rd_item ? rdata : '0;
    end
  end

endmodule

[hdl/tmcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Controller of the console writer: reset clearing pass, item acceptance,
// clear and scroll sweeps and hand-over of the result.
// ----------------------------------------------------------------------------
module tmcw_ctrl
  import tmcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_INIT: begin
        ctl.fill_wr   = 1'b1;
        ctl.sweep_inc = 1'b1;
        if (st.sweep_last) begin
          ctl.sweep_clr = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept    = 1'b1;
          ctl.sweep_clr = 1'b1;
          if (st.is_clear) begin
            state_next = ST_CLEAR;
          end else if (st.need_scroll) begin
            state_next = ST_COPY;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_CLEAR: begin
        ctl.fill_wr   = 1'b1;
        ctl.sweep_inc = 1'b1;
        if (st.sweep_last) begin
          ctl.sweep_clr = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_COPY: begin
        ctl.copy_rd   = 1'b1;
        ctl.sweep_inc = 1'b1;
        if (st.sweep_last_copy) begin
          state_next = ST_DRAIN;
        end
      end
      // The last copied cell is written back in this cycle.
      ST_DRAIN: begin
        state_next = ST_BLANK;
      end
      ST_BLANK: begin
        ctl.blank_wr  = 1'b1;
        ctl.sweep_inc = 1'b1;
        if (st.sweep_last) begin
          ctl.sweep_clr = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/text_mode_console_writer_core.sv]
// ----------------------------------------------------------------------------
// text_mode_console_writer_core
// Character-cell console of 25 rows by 80 columns with a cursor.
//
// The input channel (in_valid/in_ready) carries one command per transaction:
// put character (with newline and optional backspace handling), clear
// screen, or read one cell. The output channel (out_valid/out_ready) returns
// exactly one transaction per command: the cursor after the command and,
// for a read, the cell word (zero otherwise).
// A put, newline, backspace or read goes from acceptance to the finish
// state, which loads the output register once it is free, and then back to
// idle, where the next command is taken; no command is taken before then.
// A put that moves past the last row scrolls the screen: it copies 1920
// cells one row up, passes a drain state and blanks the 80 cells of the
// last row before its result is loaded. A clear walks all 2000 cells.
// Commands are taken one at a time.
// After reset the block runs a clearing pass over all 2000 cells with
// in_ready low, with the cursor at row 0, column 0. The result sits in an
// output register, so a new command is accepted while the receiver stalls;
// its own result waits until the previous one has been taken.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core
  import tmcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        cmd,
  input  logic [7:0]        char_code,
  input  logic [7:0]        attribute,
  input  logic              interpret_backspace,
  input  logic [ROW_W-1:0]  read_row,
  input  logic [COL_W-1:0]  read_col,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COL_W-1:0]  cursor_col_out,
  output logic [ROW_W-1:0]  cursor_row_out,
  output logic [CELL_W-1:0] cell_value
);

  dp_cmd_t    ctl;
  dp_status_t st;

  tmcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  tmcw_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .ctl                 (ctl),
    .st                  (st),
    .cmd                 (cmd),
    .char_code           (char_code),
    .attribute           (attribute),
    .interpret_backspace (interpret_backspace),
    .read_row            (read_row),
    .read_col            (read_col),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .cursor_col_out      (cursor_col_out),
    .cursor_row_out      (cursor_row_out),
    .cell_value          (cell_value)
  );

endmodule

[test/text_mode_console_writer_core_test.sv]
// ----------------------------------------------------------------------------
// text_mode_console_writer_core_test
// Self-checking bench for the text-mode console writer. A queue of console
// commands (directed corner cases, then random text, read-back, clear and
// noise traffic) feeds a clocked driver with random idle gaps. A clocked
// monitor applies random back-pressure and compares every result with the
// output of a shadow screen and cursor kept inside the bench.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core_test;
  import tmcw_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1850;
  localparam int SLOW_CYCLES  = 2010;  // scroll or clear sweep, with margin
  localparam int FAST_CYCLES  = 2;
  localparam int TAIL_CYCLES  = 2100;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       ch;
    logic [7:0]       attr;
    logic             bs;
    logic [ROW_W-1:0] rrow;
    logic [COL_W-1:0] rcol;
    logic [2:0]       gap;
  } console_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] word;
  } console_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COL_W-1:0]  cursor_col_out;
  logic [ROW_W-1:0]  cursor_row_out;
  logic [CELL_W-1:0] cell_value;
  console_item_t driving = '0;

  console_item_t   pending_cmds[$];
  console_result_t expected_results[$];

  // Shadow copy of the screen and the cursor.
  logic [CELL_W-1:0] shadow_screen [CELLS];
  int cur_col;
  int cur_row;

  int   errors = 0;
  int   cycles = 0;
  int   budget = 4 * (CELLS + 3 * TAIL_CYCLES);
  int   idle_left = 0;
  int   stall_left = 0;
  int   results_seen = 0;
  logic gen_calm = 1'b0;

  text_mode_console_writer_core u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .cmd                 (driving.op),
    .char_code           (driving.ch),
    .attribute           (driving.attr),
    .interpret_backspace (driving.bs),
    .read_row            (driving.rrow),
    .read_col            (driving.rcol),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .cursor_col_out      (cursor_col_out),
    .cursor_row_out      (cursor_row_out),
    .cell_value          (cell_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic fill_shadow(input logic [CELL_W-1:0] word);
    int i;
    for (i = 0; i < CELLS; i++) shadow_screen[i] = word;
  endtask

  // Applies one command to the shadow screen and works out its result.
  task automatic apply_console_cmd(input console_item_t it, output console_result_t res,
                                   output bit slow);
    int i;
    logic [CELL_W-1:0] read_word;
    slow = 1'b0;
    read_word = '0;
    case (it.op)
      CMD_PUT: begin
        if (it.ch == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (it.ch == CH_BACKSPACE && it.bs) begin
          if (cur_col > 0) begin
            cur_col--;
            shadow_screen[cur_row * COLS + cur_col] = BLANK_WHITE;
          end
        end else begin
          shadow_screen[cur_row * COLS + cur_col] = {it.attr, it.ch};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // Moving past the last row scrolls everything up by one row.
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
          for (i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = BLANK_WHITE;
          cur_row = ROWS - 1;
          slow = 1'b1;
        end
      end
      CMD_CLEAR: begin
        fill_shadow({it.attr[3:0], 12'h000} | BLANK_PLAIN);
        cur_col = 0;
        cur_row = 0;
        slow = 1'b1;
      end
      CMD_READ: begin
        if (int'(it.rrow) < ROWS && int'(it.rcol) < COLS)
          read_word = shadow_screen[int'(it.rrow) * COLS + int'(it.rcol)];
      end
      default: begin
      end
    endcase
    res.col  = cur_col[COL_W-1:0];
    res.row  = cur_row[ROW_W-1:0];
    res.word = read_word;
  endtask

  function automatic console_item_t make_item(input logic [1:0] op, input logic [7:0] ch,
                                              input logic [7:0] attr, input logic bs,
                                              input logic [ROW_W-1:0] rrow,
                                              input logic [COL_W-1:0] rcol);
    console_item_t it;
    it.op   = op;
    it.ch   = ch;
    it.attr = attr;
    it.bs   = bs;
    it.rrow = rrow;
    it.rcol = rcol;
    it.gap  = gen_calm ? 3'd0 : 3'($urandom_range(0, 7));
    return it;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // Driver: one transaction at a time from the pending queue.
  always @(posedge clk) begin
    console_result_t want;
    bit slow;
    if (rst) begin
      in_valid  <= 1'b0;
      idle_left <= 0;
    end else if (in_valid && in_ready) begin
      apply_console_cmd(driving, want, slow);
      expected_results.push_back(want);
      budget <= budget + 4 * ((slow ? SLOW_CYCLES : FAST_CYCLES) + 18);
      if (pending_cmds.size() != 0 && pending_cmds[0].gap == 0) begin
        driving <= pending_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
        if (pending_cmds.size() != 0) idle_left <= int'(pending_cmds[0].gap);
      end
    end else if (!in_valid && pending_cmds.size() != 0) begin
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
      end else begin
        driving  <= pending_cmds.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor: random back-pressure, with calm stretches of no stalling.
  always @(posedge clk) begin
    console_result_t want;
    int next_stall;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result transaction", int'(cursor_col_out), 0);
      end else begin
        want = expected_results.pop_front();
        if (cursor_col_out !== want.col)
          note_mismatch("cursor column", int'(cursor_col_out), int'(want.col));
        if (cursor_row_out !== want.row)
          note_mismatch("cursor row", int'(cursor_row_out), int'(want.row));
        if (cell_value !== want.word)
          note_mismatch("cell value", int'(cell_value), int'(want.word));
      end
      results_seen++;
      next_stall = ((results_seen / 40) % 3 == 0) ? 0 : $urandom_range(0, 7);
      if (next_stall != 0) begin
        out_ready  <= 1'b0;
        stall_left <= next_stall - 1;
      end
    end else if (!out_ready) begin
      if (stall_left != 0) stall_left <= stall_left - 1;
      else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > budget) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int kind;
    int len;
    int nl_pct;
    int r;
    int k;
    logic [7:0] ch;

    fill_shadow(BLANK_PLAIN);
    cur_col = 0;
    cur_row = 0;

    // Directed corner cases, starting from the freshly cleared screen.
    pending_cmds.push_back(make_item(CMD_READ, 8'h00, 8'h00, 1'b0, 5'd0, 7'd0));
    pending_cmds.push_back(make_item(CMD_READ, 8'hFF, 8'hFF, 1'b1, 5'd24, 7'd79));
    pending_cmds.push_back(make_item(CMD_READ, 8'h00, 8'h00, 1'b0, 5'd25, 7'd0));
    pending_cmds.push_back(make_item(CMD_READ, 8'h00, 8'h00, 1'b0, 5'd0, 7'd80));
    pending_cmds.push_back(make_item(CMD_READ, 8'h00, 8'h00, 1'b0, 5'd31, 7'd127));
    pending_cmds.push_back(make_item(CMD_PUT, 8'h41, 8'hFF, 1'b1, 5'd31, 7'd127));
    pending_cmds.push_back(make_item(CMD_PUT, 8'h00, 8'h00, 1'b0, 5'd0, 7'd0));
    pending_cmds.push_back(make_item(CMD_PUT, 8'hFF, 8'h80, 1'b0, 5'd0, 7'd0));
    // Backspace steps back over the last glyph and blanks it.
    pending_cmds.push_back(make_item(CMD_PUT, CH_BACKSPACE, 8'h12, 1'b1, 5'd0, 7'd0));
    // With interpretation off, byte 8 is an ordinary glyph.
    pending_cmds.push_back(make_item(CMD_PUT, CH_BACKSPACE, 8'h34, 1'b0, 5'd0, 7'd0));
    pending_cmds.push_back(make_item(CMD_READ, 8'h00, 8'h00, 1'b0, 5'd0, 7'd1));
    pending_cmds.push_back(make_item(CMD_READ, 8'h00, 8'h00, 1'b0, 5'd0, 7'd2));
    pending_cmds.push_back(make_item(CMD_PUT, CH_NEWLINE, 8'hFF, 1'b1, 5'd0, 7'd0));
    // Backspace at column 0 leaves everything as it is.
    pending_cmds.push_back(make_item(CMD_PUT, CH_BACKSPACE, 8'hFF, 1'b1, 5'd0, 7'd0));
    pending_cmds.push_back(make_item(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1, 5'd31, 7'd127));
    pending_cmds.push_back(make_item(CMD_CLEAR, 8'h00, 8'hFF, 1'b0, 5'd0, 7'd0));
    pending_cmds.push_back(make_item(CMD_READ, 8'h00, 8'h00, 1'b0, 5'd12, 7'd40));
    pending_cmds.push_back(make_item(CMD_PUT, 8'h7E, 8'h5A, 1'b0, 5'd0, 7'd0));
    pending_cmds.push_back(make_item(CMD_CLEAR, 8'hFF, 8'hF0, 1'b1, 5'd31, 7'd127));
    pending_cmds.push_back(make_item(CMD_READ, 8'h00, 8'h00, 1'b0, 5'd24, 7'd79));
    pending_cmds.push_back(make_item(CMD_READ, 8'h00, 8'h00, 1'b0, 5'd0, 7'd0));

    k = pending_cmds.size() + RANDOM_ITEMS;
    while (pending_cmds.size() < k) begin
      kind = $urandom_range(0, 99);
      gen_calm = ($urandom_range(0, 3) == 0);
      if (kind < 60) begin
        // Text burst: either short lines or long lines that wrap.
        len = $urandom_range(5, 60);
        nl_pct = $urandom_range(0, 1) ? 12 : 1;
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < nl_pct) ch = CH_NEWLINE;
          else if (r < nl_pct + 8) ch = CH_BACKSPACE;
          else ch = 8'($urandom_range(0, 255));
          pending_cmds.push_back(make_item(CMD_PUT, ch, 8'($urandom_range(0, 255)),
                                           (r < nl_pct + 8) ? ($urandom_range(0, 3) != 0)
                                                            : 1'($urandom_range(0, 1)),
                                           5'($urandom_range(0, 31)),
                                           7'($urandom_range(0, 127))));
        end
      end else if (kind < 85) begin
        len = $urandom_range(3, 15);
        repeat (len) begin
          if ($urandom_range(0, 6) == 0)
            pending_cmds.push_back(make_item(CMD_READ, 8'($urandom_range(0, 255)),
                                             8'($urandom_range(0, 255)),
                                             1'($urandom_range(0, 1)),
                                             5'($urandom_range(0, 31)),
                                             7'($urandom_range(0, 127))));
          else
            pending_cmds.push_back(make_item(CMD_READ, 8'($urandom_range(0, 255)),
                                             8'($urandom_range(0, 255)),
                                             1'($urandom_range(0, 1)),
                                             5'($urandom_range(0, ROWS - 1)),
                                             7'($urandom_range(0, COLS - 1))));
        end
      end else if (kind < 95) begin
        pending_cmds.push_back(make_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                         5'($urandom_range(0, 31)),
                                         7'($urandom_range(0, 127))));
      end else if (kind < 98) begin
        pending_cmds.push_back(make_item(CMD_CLEAR, 8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                         5'($urandom_range(0, 31)),
                                         7'($urandom_range(0, 127))));
        repeat (3)
          pending_cmds.push_back(make_item(CMD_READ, 8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           1'($urandom_range(0, 1)),
                                           5'($urandom_range(0, ROWS - 1)),
                                           7'($urandom_range(0, COLS - 1))));
      end else begin
        // A run of newlines drives the cursor down into repeated scrolling.
        len = $urandom_range(10, 30);
        repeat (len)
          pending_cmds.push_back(make_item(CMD_PUT, CH_NEWLINE, 8'($urandom_range(0, 255)),
                                           1'($urandom_range(0, 1)),
                                           5'($urandom_range(0, 31)),
                                           7'($urandom_range(0, 127))));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
